### hdl/sliding_window_anomaly_detector_defines.svh
// Assertion macros for the anomaly detector. Each use expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_ANOMALY_DETECTOR_DEFINES_SVH
`define SLIDING_WINDOW_ANOMALY_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWAD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWAD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/swad_pkg.sv
`timescale 1ns / 1ps

package swad_pkg;

    localparam int CAPACITY  = 32;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LEVEL_W   = 32;
    localparam int TIME_W    = 32;
    localparam int CTR_W     = 32;
    localparam int WIN_W     = 6;
    localparam int THR_W     = 32;
    localparam int SUM_W     = LEVEL_W + CNT_W;
    localparam int HI_W      = SUM_W - 32;
    localparam int LN_W      = LEVEL_W + CNT_W;
    localparam int PROD_W    = THR_W + SUM_W;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DAT_W  = 64;
    localparam int OUT_DAT_W = 72;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(1);

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = WIN_W'(32);
    localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(131072);

    typedef struct packed {
        logic capture;   // latch the input request, clear the accumulators
        logic scan;      // walk the stored records
        logic mul;       // form the products
        logic diff;      // combine partial products, form |level*n - sum|
        logic finish;    // compare, store the record, load the result
        logic cfg_wr;    // configuration write
    } swad_cmd_t;

    typedef struct packed {
        logic             scan_done;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] win;
    } swad_status_t;

endpackage

### hdl/swad_ctrl.sv
`timescale 1ns / 1ps

module swad_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  swad_pkg::swad_status_t status,
    output swad_pkg::swad_cmd_t   cmd
);
    import swad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cfg_wr = cfg_valid && cfg_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the result register can take the new result
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/swad_dp.sv
`timescale 1ns / 1ps

module swad_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  swad_pkg::swad_cmd_t              cmd,
    output swad_pkg::swad_status_t           status,
    input  logic [swad_pkg::LEVEL_W-1:0]     traffic_level,
    input  logic [swad_pkg::TIME_W-1:0]      now_seconds,
    input  logic [swad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swad_pkg::CFG_DAT_W-1:0]   cfg_data,
    output logic                             attack,
    output logic [swad_pkg::CTR_W-1:0]       packets_seen,
    output logic [swad_pkg::CTR_W-1:0]       packets_flagged
);
    import swad_pkg::*;

    // configuration and record bookkeeping
    logic [WIN_W-1:0]   window_len_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [ADDR_W-1:0]  oldest_reg;
    logic [CTR_W-1:0]   seen_reg;
    logic [CTR_W-1:0]   flagged_reg;
    logic [CNT_W-1:0]   win;

    // record memories
    logic [LEVEL_W-1:0] level_mem [CAPACITY];
    logic [TIME_W-1:0]  stamp_mem [CAPACITY];
    logic [LEVEL_W-1:0] rd_level_reg;
    logic [TIME_W-1:0]  rd_stamp_reg;

    // per-item working registers
    logic [LEVEL_W-1:0] level_in_reg;
    logic [TIME_W-1:0]  now_in_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               rdv_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [LN_W-1:0]    ln_reg;
    logic [63:0]        plo_reg;
    logic [THR_W+HI_W-1:0] phi_reg;
    logic [PROD_W-1:0]  rhs_reg;
    logic [LN_W-1:0]    d_reg;

    logic [TIME_W-1:0]  age;
    logic               in_window;
    logic               issue;
    logic               flag;
    logic [ADDR_W-1:0]  slot;
    logic               filling;
    logic [CNT_W-1:0]   oldest_inc;

    logic               attack_reg;
    logic [CTR_W-1:0]   seen_out_reg;
    logic [CTR_W-1:0]   flagged_out_reg;

    // a zero window acts as one, anything above capacity as capacity
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            win = CNT_W'(1);
        end
        else if (CNT_W'(window_len_reg) > CNT_W'(CAPACITY) ||
                 WIN_W'(CNT_W'(window_len_reg)) != window_len_reg)
        begin
            win = CNT_W'(CAPACITY);
        end
        else
        begin
            win = CNT_W'(window_len_reg);
        end
    end

    assign issue     = cmd.scan && (idx_reg < fill_reg);
    assign age       = now_in_reg - rd_stamp_reg;
    assign in_window = (age <= TIME_W'(win));

    assign status.scan_done = (idx_reg >= fill_reg) && !rdv_reg;
    assign status.fill      = fill_reg;
    assign status.win       = win;

    assign filling    = (fill_reg < win);
    assign slot       = filling ? fill_reg[ADDR_W-1:0] : oldest_reg;
    assign oldest_inc = CNT_W'(oldest_reg) + CNT_W'(1);

    always_comb
    begin
        if (sum_reg != '0)
        begin
            flag = (PROD_W'({d_reg, FRAC_W'(0)}) > rhs_reg);
        end
        else
        begin
            flag = (level_in_reg > threshold_reg);
        end
    end

    // configuration, record bookkeeping and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            threshold_reg  <= THRESHOLD_RST;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            seen_reg       <= '0;
            flagged_reg    <= '0;
        end
        else if (cmd.cfg_wr && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_THRESHOLD))
        begin
            if (cfg_index == REG_WINDOW_LEN)
            begin
                window_len_reg <= cfg_data[WIN_W-1:0];
            end
            else
            begin
                threshold_reg <= cfg_data[THR_W-1:0];
            end
            fill_reg    <= '0;
            oldest_reg  <= '0;
            seen_reg    <= '0;
            flagged_reg <= '0;
        end
        else if (cmd.finish)
        begin
            seen_reg <= seen_reg + CTR_W'(1);
            if (flag)
            begin
                flagged_reg <= flagged_reg + CTR_W'(1);
            end
            if (filling)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (oldest_inc == win)
            begin
                oldest_reg <= '0;
            end
            else
            begin
                oldest_reg <= oldest_inc[ADDR_W-1:0];
            end
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= issue;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // record memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            level_mem[slot] <= level_in_reg;
            stamp_mem[slot] <= now_in_reg;
        end
        rd_level_reg <= level_mem[idx_reg[ADDR_W-1:0]];
        rd_stamp_reg <= stamp_mem[idx_reg[ADDR_W-1:0]];
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            level_in_reg <= traffic_level;
            now_in_reg   <= now_seconds;
            sum_reg      <= '0;
            n_reg        <= '0;
        end
        else if (rdv_reg && in_window)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_level_reg);
            n_reg   <= n_reg + CNT_W'(1);
        end

        if (cmd.mul)
        begin
            ln_reg  <= LN_W'(level_in_reg) * LN_W'(n_reg);
            plo_reg <= 64'(threshold_reg) * 64'(sum_reg[31:0]);
            phi_reg <= (THR_W+HI_W)'(threshold_reg) * (THR_W+HI_W)'(sum_reg[SUM_W-1:32]);
        end

        if (cmd.diff)
        begin
            rhs_reg <= PROD_W'({phi_reg, 32'd0}) + PROD_W'(plo_reg);
            if (ln_reg >= LN_W'(sum_reg))
            begin
                d_reg <= ln_reg - LN_W'(sum_reg);
            end
            else
            begin
                d_reg <= LN_W'(sum_reg) - ln_reg;
            end
        end

        if (cmd.finish)
        begin
            attack_reg      <= flag;
            seen_out_reg    <= seen_reg + CTR_W'(1);
            flagged_out_reg <= flag ? (flagged_reg + CTR_W'(1)) : flagged_reg;
        end
    end

    assign attack          = attack_reg;
    assign packets_seen    = seen_out_reg;
    assign packets_flagged = flagged_out_reg;

endmodule

### hdl/sliding_window_anomaly_detector.sv
// Moving-average deviation detector. Each request on the s_ side carries a traffic
// level (unsigned Q16.16) and a time in seconds. The block adds up the stored levels
// whose age (now minus stamp, wrapping at 32 bits) is at most the effective window,
// counts them (n, sum S), and flags the request when |level*n - S| * 2^16 exceeds
// threshold * S, or, when S is zero, when level exceeds threshold. The request is
// then recorded, replacing the oldest record once the window is full. Each request
// yields exactly one result request on the m_ side with the flag and the running
// seen/flagged counters. One request is in work at a time. After acceptance the
// block walks the records held (at most 32), one read per cycle, then multiplies,
// combines and compares. It loads the result once the output register is free,
// and the input side reopens at the same clock edge. The result sits in an output
// register, so the next request is taken while a result still waits. Writing
// either configuration register drops all records and zeroes both counters;
// write only while no request is in work.
// A window_len of 0 acts as 1, one above 32 acts as 32.
`timescale 1ns / 1ps

module sliding_window_anomaly_detector
(
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [31:0] traffic_level, [63:32] now_seconds
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swad_pkg::IN_DAT_W-1:0]      s_tdata,
    // m_tdata: [0] attack, [32:1] packets_seen, [64:33] packets_flagged, rest zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swad_pkg::OUT_DAT_W-1:0]     m_tdata,
    // cfg_index 0: window_len (cfg_data[5:0]), 1: threshold (cfg_data[31:0])
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swad_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import swad_pkg::*;

`include "sliding_window_anomaly_detector_defines.svh"

    swad_cmd_t          cmd;
    swad_status_t       status;
    logic               attack;
    logic [CTR_W-1:0]   packets_seen;
    logic [CTR_W-1:0]   packets_flagged;

    // sequencing: accept, walk records, multiply, combine, compare and record
    swad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // record memories, accumulators, multipliers and counters
    swad_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .traffic_level   (s_tdata[LEVEL_W-1:0]),
        .now_seconds     (s_tdata[LEVEL_W+TIME_W-1:LEVEL_W]),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .attack          (attack),
        .packets_seen    (packets_seen),
        .packets_flagged (packets_flagged)
    );

    // pack the result, zero fill to whole bytes
    assign m_tdata = OUT_DAT_W'({packets_flagged, packets_seen, attack});

    // one request in work at a time: acceptance closes the input side
    `SWAD_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted while a request is still in work")

    // configuration is taken only when the input side is open
    `SWAD_ASSERT_IMP(a_cfg_when_idle, cfg_valid && cfg_ready, s_tready,
        "configuration write taken while busy")

    // the record count never exceeds the effective window
    `SWAD_ASSERT_IMP(a_fill_in_window, 1'b1, status.fill <= status.win,
        "record count beyond window")

endmodule

### tb/sliding_window_anomaly_detector_test.sv
`timescale 1ns / 1ps

module sliding_window_anomaly_detector_test;

    import swad_pkg::*;

    // cycles with no handshake of any kind before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // window of cycles in which neither side idles
    localparam int QUIET_FROM  = 15000;
    localparam int QUIET_TO    = 21000;
    localparam int SHOW_MAX    = 10;

    // indexes past the register list; the block must ignore these writes
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    typedef struct packed {
        logic             attack;
        logic [CTR_W-1:0] seen;
        logic [CTR_W-1:0] flagged;
    } verdict_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DAT_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_DAT_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // requests waiting for the driver, verdicts waiting for the monitor
    logic [IN_DAT_W-1:0]  sample_queue [$];
    verdict_t             verdict_queue [$];

    int unsigned          issued;
    int unsigned          taken;
    int unsigned          failures;
    int unsigned          shown;
    int unsigned          cycle_count;
    int unsigned          stall_cycles;

    // shadow copy of the detector: configuration, record ring and counters
    logic [WIN_W-1:0]     win_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [LEVEL_W-1:0]   level_mem [CAPACITY];
    logic [TIME_W-1:0]    stamp_mem [CAPACITY];
    int unsigned          held;
    int unsigned          head;
    logic [CTR_W-1:0]     seen_ctr;
    logic [CTR_W-1:0]     flag_ctr;

    // traffic generator state: running clock and typical level of the phase
    logic [TIME_W-1:0]    gen_now;
    logic [LEVEL_W-1:0]   gen_base;

    sliding_window_anomaly_detector u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Window length actually in force: zero acts as one, anything past the
    // ring size acts as the ring size. It bounds both record count and age.
    function automatic int unsigned span();
        if (win_reg == '0)
            return 1;
        if (win_reg > CAPACITY)
            return CAPACITY;
        return win_reg;
    endfunction

    function automatic void drop_records();
        held     = 0;
        head     = 0;
        seen_ctr = '0;
        flag_ctr = '0;
    endfunction

    // Mirror a configuration write; unknown indexes leave everything alone.
    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DAT_W-1:0] val);
        if (idx == REG_WINDOW_LEN)
        begin
            win_reg = val[WIN_W-1:0];
            drop_records();
        end
        else if (idx == REG_THRESHOLD)
        begin
            thr_reg = val[THR_W-1:0];
            drop_records();
        end
    endfunction

    // Score one request against the records still inside the window, then
    // record it and queue the verdict the block must produce.
    function automatic void judge_sample(input logic [IN_DAT_W-1:0] data);
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  age;
        logic [63:0]        total;
        logic [63:0]        cnt;
        logic [63:0]        scaled;
        logic [63:0]        dev;
        logic [127:0]       lhs;
        logic [127:0]       rhs;
        int unsigned        w;
        int unsigned        slot;
        int unsigned        i;
        logic               flag;
        verdict_t           v;
        level    = data[LEVEL_W-1:0];
        now      = data[LEVEL_W +: TIME_W];
        w        = span();
        total    = '0;
        cnt      = '0;
        seen_ctr = seen_ctr + 1'b1;
        for (i = 0; i < held; i++)
        begin
            // wrapping age: a stamp from the future looks ancient and drops out
            age = now - stamp_mem[i];
            if (age <= w)
            begin
                total = total + level_mem[i];
                cnt   = cnt + 1;
            end
        end
        if (total != 0)
        begin
            // |level - avg| / avg > thr, cross-multiplied, exact in 128 bits
            scaled = 64'(level) * cnt;
            dev    = (scaled >= total) ? scaled - total : total - scaled;
            lhs    = 128'(dev) << FRAC_W;
            rhs    = 128'(thr_reg) * 128'(total);
            flag   = lhs > rhs;
        end
        else
        begin
            flag = level > thr_reg;
        end
        if (held < w)
        begin
            slot = (head + held) % w;
            held++;
        end
        else
        begin
            slot = head % w;
            head = (slot + 1) % w;
        end
        level_mem[slot] = level;
        stamp_mem[slot] = now;
        if (flag)
            flag_ctr = flag_ctr + 1'b1;
        v.attack  = flag;
        v.seen    = seen_ctr;
        v.flagged = flag_ctr;
        verdict_queue.push_back(v);
    endfunction

    function automatic logic take_break();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 255);
            1:       return $urandom_range(32'h0000_8000, 32'h0004_0000);
            2:       return $urandom_range(1, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Mostly steady traffic with small clock steps so the window fills and
    // the averages mean something; the rest is spikes, silence, clock jumps
    // and fully random requests (clock running backwards included).
    function automatic logic [IN_DAT_W-1:0] next_sample();
        int unsigned        pick;
        logic [LEVEL_W-1:0] level;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            gen_now = gen_now + $urandom_range(0, 2);
            if (pick < 6)
                level = gen_base * $urandom_range(2, 5);
            else if (pick < 9)
                level = '0;
            else
                level = gen_base - (gen_base >> 3) + $urandom_range(0, gen_base >> 2);
        end
        else if (pick < 90)
        begin
            gen_now = gen_now + $urandom_range(0, 2);
            level   = $urandom;
        end
        else if (pick < 95)
        begin
            gen_now = gen_now + $urandom_range(3, 80);
            level   = gen_base;
        end
        else
        begin
            gen_now = $urandom;
            level   = $urandom;
        end
        return {gen_now, level};
    endfunction

    function automatic void feed(input logic [TIME_W-1:0] now,
                                 input logic [LEVEL_W-1:0] level);
        sample_queue.push_back({now, level});
        issued++;
    endfunction

    // Hold the sender until every request is taken and every verdict is in.
    task automatic drain();
        do
            @(posedge clk);
        while (taken != issued || verdict_queue.size() != 0);
    endtask

    task automatic run_random(input int unsigned count);
        logic [IN_DAT_W-1:0] d;
        repeat (count)
        begin
            d = next_sample();
            sample_queue.push_back(d);
            issued++;
        end
        drain();
    endtask

    // One register write request; mirror it once the block takes it.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        write_register(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Window writes carry random junk above the six live bits.
    task automatic set_window(input logic [WIN_W-1:0] win);
        write_cfg(REG_WINDOW_LEN, ($urandom & ~CFG_DAT_W'(6'h3F)) | CFG_DAT_W'(win));
    endtask

    // Driver: score a request the cycle it is taken, then advance to the next
    // pending one unless this cycle idles. Hold the request while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                judge_sample(s_tdata);
                taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sample_queue.size() != 0 && !take_break())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_queue.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: match each verdict request against the oldest prediction,
    // field by field; stall the result side now and then.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    failures++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("unexpected verdict: %h", m_tdata);
                    end
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (m_tdata[0] !== want.attack
                        || m_tdata[CTR_W:1] !== want.seen
                        || m_tdata[2*CTR_W:CTR_W+1] !== want.flagged)
                    begin
                        failures++;
                        if (shown < SHOW_MAX)
                        begin
                            shown++;
                            $display("verdict mismatch: expected attack=%0b seen=%0d flagged=%0d, got attack=%0b seen=%0d flagged=%0d",
                                     want.attack, want.seen, want.flagged, m_tdata[0],
                                     m_tdata[CTR_W:1], m_tdata[2*CTR_W:CTR_W+1]);
                        end
                    end
                end
            end
            m_tready <= !take_break();
        end
    end

    // Watchdog: count cycles in which no handshake completes on any channel.
    always @(posedge clk)
    begin
        cycle_count++;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        win_reg  = WINDOW_LEN_RST;
        thr_reg  = THRESHOLD_RST;
        drop_records();
        gen_now  = '0;
        gen_base = 32'h0001_0000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset settings (window 32, threshold 2.0): empty window, level
        // extremes, age exactly at the window edge and one past it, a clock
        // running backwards, and a clock wrapping through zero.
        feed(32'd0,          32'h0000_0000);
        feed(32'd0,          32'hFFFF_FFFF);
        feed(32'd1,          32'h0001_0000);
        feed(32'd2,          32'h0001_0000);
        feed(32'd3,          32'h0002_0000);
        feed(32'd3,          32'h0001_0000);
        feed(32'd35,         32'h0005_0000);
        feed(32'd36,         32'h0001_0000);
        feed(32'd10,         32'h0001_0000);
        feed(32'd10,         32'h0003_0000);
        feed(32'hFFFF_FFFF,  32'h0001_0000);
        feed(32'd0,          32'h0001_0000);
        feed(32'd1,          32'h0001_0000);
        feed(32'd2,          32'h0000_0000);
        feed(32'd3,          32'hFFFF_FFFF);
        feed(32'hFFFF_FFFF,  32'hFFFF_FFFF);
        drain();

        // Window zero acts as one; threshold zero flags any deviation.
        set_window(6'd0);
        write_cfg(REG_THRESHOLD, 32'h0000_0000);
        feed(32'd5, 32'h0000_0100);
        feed(32'd6, 32'h0000_0100);
        feed(32'd7, 32'h0000_0200);
        feed(32'd9, 32'h0000_0200);
        feed(32'd9, 32'h0000_0000);
        drain();
        gen_base = pick_base();
        run_random(150);

        // Widest encodable window acts as full ring; threshold at its top.
        set_window(6'd63);
        write_cfg(REG_THRESHOLD, 32'hFFFF_FFFF);
        feed(32'd100, 32'hFFFF_FFFF);
        drain();
        gen_base = pick_base();
        run_random(150);

        // Just past the ring size; split so the sender waits out the block.
        set_window(6'd33);
        write_cfg(REG_THRESHOLD, 32'h0000_8000);
        gen_base = pick_base();
        run_random(125);
        run_random(125);

        // Writes to indexes past the list must keep records and counters.
        write_cfg(REG_SPARE_LO, $urandom);
        write_cfg(REG_SPARE_HI, $urandom);
        run_random(100);

        set_window(6'd1);
        write_cfg(REG_THRESHOLD, 32'h0001_0000);
        gen_base = pick_base();
        run_random(150);

        set_window(6'd32);
        write_cfg(REG_THRESHOLD, 32'h0001_8000);
        gen_base = pick_base();
        run_random(400);

        repeat (4)
        begin
            set_window(6'($urandom_range(1, 32)));
            write_cfg(REG_THRESHOLD, $urandom_range(32'h0000_4000, 32'h0004_0000));
            gen_base = pick_base();
            run_random(160);
        end

        drain();
        repeat (60) @(posedge clk);
        if (verdict_queue.size() != 0)
            failures++;
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sliding_window_anomaly_detector.f
+incdir+hdl
hdl/swad_pkg.sv
hdl/swad_ctrl.sv
hdl/swad_dp.sv
hdl/sliding_window_anomaly_detector.sv
tb/sliding_window_anomaly_detector_test.sv
